/* hdl/cpas_pkg.sv */
// cpas_pkg: types and constants for the cascaded position and attitude setpoint block
// no dependencies; imported by cascaded_position_attitude_setpoint

package cpas_pkg;

    localparam int NUM_CFG  = 8;
    localparam int ROT_FRAC = 28;
    localparam int ACC_W    = 68;
    localparam int MUL_W    = 67;
    localparam int DIVN_W   = 61;
    localparam int QUO_W    = 29;

    localparam logic [2:0] CFG_TARGET_X   = 3'd0;
    localparam logic [2:0] CFG_TARGET_Y   = 3'd1;
    localparam logic [2:0] CFG_TARGET_Z   = 3'd2;
    localparam logic [2:0] CFG_THRUST_G   = 3'd3;
    localparam logic [2:0] CFG_ROLL_PG    = 3'd4;
    localparam logic [2:0] CFG_ROLL_VG    = 3'd5;
    localparam logic [2:0] CFG_PITCH_PG   = 3'd6;
    localparam logic [2:0] CFG_PITCH_VG   = 3'd7;

    localparam logic signed [31:0] CFG_RESET [NUM_CFG] = '{
        32'sd0, 32'sd0, 32'sd0, 32'sd65536, 32'sd328, 32'sd1311, 32'sd328, 32'sd1311
    };

    // product groups of the multiply-accumulate pass
    localparam logic [2:0] G_BX    = 3'd0;
    localparam logic [2:0] G_BY    = 3'd1;
    localparam logic [2:0] G_BZ    = 3'd2;
    localparam logic [2:0] G_VX    = 3'd3;
    localparam logic [2:0] G_VY    = 3'd4;
    localparam logic [2:0] G_THR   = 3'd5;
    localparam logic [2:0] G_ROLL  = 3'd6;
    localparam logic [2:0] G_PITCH = 3'd7;

    // quaternion part indexes
    localparam logic [1:0] Q_W = 2'd0;
    localparam logic [1:0] Q_X = 2'd1;
    localparam logic [1:0] Q_Y = 2'd2;
    localparam logic [1:0] Q_Z = 2'd3;

    // products ww xx yy zz xy wz xz wy yz wx
    localparam logic [1:0] QA_IDX [10] = '{Q_W, Q_X, Q_Y, Q_Z, Q_X, Q_W, Q_X, Q_W, Q_Y, Q_W};
    localparam logic [1:0] QB_IDX [10] = '{Q_W, Q_X, Q_Y, Q_Z, Q_Y, Q_Z, Q_Z, Q_Y, Q_Z, Q_X};

    typedef enum logic [2:0] {
        S_IDLE,
        S_QMUL,
        S_DIV_LD,
        S_DIV_IT,
        S_MAC,
        S_OUT
    } t_state;

    typedef enum logic [1:0] {
        PH_MUL,
        PH_ACC,
        PH_WB
    } t_phase;

    function automatic logic last_term(input logic [2:0] grp, input logic [1:0] j);
        logic r;
        if (grp <= G_VY) begin
            r = (j == 2'd2);
        end else if (grp == G_THR) begin
            r = (j == 2'd0);
        end else begin
            r = (j == 2'd1);
        end
        return r;
    endfunction

    function automatic logic [1:0] grp_row(input logic [2:0] grp);
        logic [1:0] r;
        case (grp)
            G_BX, G_VX: r = 2'd0;
            G_BY, G_VY: r = 2'd1;
            default:    r = 2'd2;
        endcase
        return r;
    endfunction

endpackage

/* hdl/cascaded_position_attitude_setpoint.sv */
// cascaded_position_attitude_setpoint: top level, sequenced datapath around one shared multiplier
// depends on cpas_pkg

// Each transaction carries position, orientation and velocity; one result transaction follows.
// With a valid pose an item takes these steps: the ten quaternion products on the shared
// 35x32 multiplier, nine rotation coefficients from a one-bit-per-cycle restoring divider,
// twenty multiply-accumulate terms and eight rounding write-backs on the same multiplier,
// and a load of the output register.
// An item with the pose flag low skips the datapath and repeats the last result.
// The input is ready only while the sequencer is idle; a finished result waits in the
// output register while the next item is taken.

module cascaded_position_attitude_setpoint
    import cpas_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [2:0]         i_cfg_idx,
    input  logic [31:0]        i_cfg_data,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic               i_pose_valid,
    input  logic signed [31:0] i_pos_x,
    input  logic signed [31:0] i_pos_y,
    input  logic signed [31:0] i_pos_z,
    input  logic signed [15:0] i_quat_w,
    input  logic signed [15:0] i_quat_x,
    input  logic signed [15:0] i_quat_y,
    input  logic signed [15:0] i_quat_z,
    input  logic signed [31:0] i_vel_x,
    input  logic signed [31:0] i_vel_y,
    input  logic signed [31:0] i_vel_z,
    output logic               o_valid,
    input  logic               i_ready,
    output logic signed [31:0] o_thrust_cmd,
    output logic signed [13:0] o_roll_cmd,
    output logic signed [13:0] o_pitch_cmd
);

    localparam logic signed [ACC_W-1:0] ERR_LIM   = 68'sd5 <<< FRAC_BITS;
    localparam logic signed [ACC_W-1:0] ANGLE_LIM =
        ((68'sd75 <<< FRAC_BITS) + 68'sd500) / 68'sd1000;
    localparam logic signed [ACC_W-1:0] THR_MAX = 68'sd2147483647;
    localparam logic signed [ACC_W-1:0] THR_MIN = -68'sd2147483648;

    t_state r_state, n_state;
    t_phase r_ph;

    logic signed [31:0]      r_cfg [NUM_CFG];
    logic signed [15:0]      r_q [4];
    logic signed [32:0]      r_ep [3];
    logic signed [32:0]      r_ev [3];
    logic signed [31:0]      r_qp [10];
    logic signed [31:0]      r_c [9];
    logic signed [34:0]      r_bx, r_by, r_bz, r_vx, r_vy;
    logic signed [MUL_W-1:0] r_prod;
    logic signed [ACC_W-1:0] r_acc;
    logic [3:0]              r_k;
    logic [2:0]              r_grp;
    logic [1:0]              r_j;
    logic [32:0]             r_s;
    logic [32:0]             r_rem;
    logic [QUO_W-1:0]        r_dq;
    logic                    r_dneg;
    logic [4:0]              r_bit;
    logic signed [31:0]      r_w_thrust;
    logic signed [13:0]      r_w_roll, r_w_pitch;
    logic                    r_o_valid;
    logic signed [31:0]      r_o_thrust;
    logic signed [13:0]      r_o_roll, r_o_pitch;

    logic signed [34:0]      mul_a;
    logic signed [31:0]      mul_b;
    logic signed [MUL_W-1:0] mul_p;
    logic [3:0]              c_idx;

    logic [32:0]             s_sum;
    logic signed [33:0]      num;
    logic [32:0]             num_mag;
    logic [DIVN_W-1:0]       div_n;
    logic [33:0]             div_t;
    logic                    div_ge;
    logic [33:0]             div_r;
    logic [QUO_W-1:0]        div_q;

    logic                    acc_neg;
    logic [ACC_W-1:0]        acc_mag;
    logic [ACC_W-1:0]        rm_rot, rm_frac, rm_sel;
    logic signed [ACC_W-1:0] rnd, rnd_neg;

    assign o_ready      = (r_state == S_IDLE);
    assign o_valid      = r_o_valid;
    assign o_thrust_cmd = r_o_thrust;
    assign o_roll_cmd   = r_o_roll;
    assign o_pitch_cmd  = r_o_pitch;

    // shared multiplier operands
    always_comb begin
        c_idx = {1'b0, grp_row(r_grp), 1'b0} + {2'b00, grp_row(r_grp)} + {2'b00, r_j};
        mul_a = '0;
        mul_b = '0;
        if (r_state == S_QMUL) begin
            mul_a = 35'(r_q[QA_IDX[r_k]]);
            mul_b = 32'(r_q[QB_IDX[r_k]]);
        end else begin
            case (r_grp)
                G_BX, G_BY, G_BZ: begin
                    mul_a = 35'(r_ep[r_j]);
                    mul_b = r_c[c_idx];
                end
                G_VX, G_VY: begin
                    mul_a = 35'(r_ev[r_j]);
                    mul_b = r_c[c_idx];
                end
                G_THR: begin
                    mul_a = r_bz;
                    mul_b = r_cfg[CFG_THRUST_G];
                end
                G_ROLL: begin
                    mul_a = (r_j == 2'd0) ? r_by : r_vy;
                    mul_b = (r_j == 2'd0) ? r_cfg[CFG_ROLL_PG] : r_cfg[CFG_ROLL_VG];
                end
                default: begin
                    mul_a = (r_j == 2'd0) ? r_bx : r_vx;
                    mul_b = (r_j == 2'd0) ? r_cfg[CFG_PITCH_PG] : r_cfg[CFG_PITCH_VG];
                end
            endcase
        end
        mul_p = mul_a * mul_b;
    end

    // rotation numerators and divider step
    always_comb begin
        s_sum = 33'(r_qp[0]) + 33'(r_qp[1]) + 33'(r_qp[2]) + 33'(r_qp[3]);
        case (r_k)
            4'd0:    num = 34'(r_qp[0]) + 34'(r_qp[1]) - 34'(r_qp[2]) - 34'(r_qp[3]);
            4'd1:    num = (34'(r_qp[4]) + 34'(r_qp[5])) <<< 1;
            4'd2:    num = (34'(r_qp[6]) - 34'(r_qp[7])) <<< 1;
            4'd3:    num = (34'(r_qp[4]) - 34'(r_qp[5])) <<< 1;
            4'd4:    num = 34'(r_qp[0]) - 34'(r_qp[1]) + 34'(r_qp[2]) - 34'(r_qp[3]);
            4'd5:    num = (34'(r_qp[8]) + 34'(r_qp[9])) <<< 1;
            4'd6:    num = (34'(r_qp[6]) + 34'(r_qp[7])) <<< 1;
            4'd7:    num = (34'(r_qp[8]) - 34'(r_qp[9])) <<< 1;
            default: num = 34'(r_qp[0]) - 34'(r_qp[1]) - 34'(r_qp[2]) + 34'(r_qp[3]);
        endcase
        num_mag = num[33] ? 33'(-num) : num[32:0];
        div_n   = {num_mag, 28'd0} + DIVN_W'(s_sum >> 1);
        div_t   = {r_rem, r_dq[QUO_W-1]};
        div_ge  = (div_t >= {1'b0, r_s});
        div_r   = div_ge ? (div_t - {1'b0, r_s}) : div_t;
        div_q   = {r_dq[QUO_W-2:0], div_ge};
    end

    // rounding to nearest, ties away from zero
    always_comb begin
        acc_neg = r_acc[ACC_W-1];
        acc_mag = acc_neg ? ACC_W'(-r_acc) : ACC_W'(r_acc);
        rm_rot  = (acc_mag + (ACC_W'(1) << (ROT_FRAC - 1))) >> ROT_FRAC;
        rm_frac = (acc_mag + (ACC_W'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
        rm_sel  = (r_grp <= G_VY) ? rm_rot : rm_frac;
        rnd     = acc_neg ? -$signed(rm_sel) : $signed(rm_sel);
        rnd_neg = -rnd;
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_state = i_pose_valid ? S_QMUL : S_OUT;
                end
            end
            S_QMUL: begin
                if (r_ph == PH_ACC && r_k == 4'd9) begin
                    n_state = S_DIV_LD;
                end
            end
            S_DIV_LD: n_state = S_DIV_IT;
            S_DIV_IT: begin
                if (r_bit == 5'(QUO_W - 1)) begin
                    n_state = (r_k == 4'd8) ? S_MAC : S_DIV_LD;
                end
            end
            S_MAC: begin
                if (r_ph == PH_WB && r_grp == G_PITCH) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (!r_o_valid || i_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_CFG; i++) begin
                r_cfg[i] <= CFG_RESET[i];
            end
            r_ph       <= PH_MUL;
            r_k        <= '0;
            r_grp      <= '0;
            r_j        <= '0;
            r_bit      <= '0;
            r_w_thrust <= '0;
            r_w_roll   <= '0;
            r_w_pitch  <= '0;
            r_o_valid  <= 1'b0;
            r_o_thrust <= '0;
            r_o_roll   <= '0;
            r_o_pitch  <= '0;
        end else begin
            if (i_cfg_we) begin
                r_cfg[i_cfg_idx] <= i_cfg_data;
            end
            if (r_state == S_OUT && (!r_o_valid || i_ready)) begin
                r_o_valid <= 1'b1;
            end else if (r_o_valid && i_ready) begin
                r_o_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_q[0]  <= i_quat_w;
                        r_q[1]  <= i_quat_x;
                        r_q[2]  <= i_quat_y;
                        r_q[3]  <= i_quat_z;
                        r_ep[0] <= 33'(r_cfg[CFG_TARGET_X]) - 33'(i_pos_x);
                        r_ep[1] <= 33'(r_cfg[CFG_TARGET_Y]) - 33'(i_pos_y);
                        r_ep[2] <= 33'(r_cfg[CFG_TARGET_Z]) - 33'(i_pos_z);
                        r_ev[0] <= -33'(i_vel_x);
                        r_ev[1] <= -33'(i_vel_y);
                        r_ev[2] <= -33'(i_vel_z);
                        r_k     <= '0;
                        r_ph    <= PH_MUL;
                    end
                end
                S_QMUL: begin
                    if (r_ph == PH_MUL) begin
                        r_prod <= mul_p;
                        r_ph   <= PH_ACC;
                    end else begin
                        r_qp[r_k] <= r_prod[31:0];
                        r_ph      <= PH_MUL;
                        r_k       <= (r_k == 4'd9) ? 4'd0 : r_k + 4'd1;
                    end
                end
                S_DIV_LD: begin
                    r_s    <= s_sum;
                    r_rem  <= {1'b0, div_n[DIVN_W-1:QUO_W]};
                    r_dq   <= div_n[QUO_W-1:0];
                    r_dneg <= num[33];
                    r_bit  <= '0;
                end
                S_DIV_IT: begin
                    r_rem <= div_r[32:0];
                    r_dq  <= div_q;
                    r_bit <= r_bit + 5'd1;
                    if (r_bit == 5'(QUO_W - 1)) begin
                        if (r_s == '0) begin
                            r_c[r_k] <= '0;
                        end else if (r_dneg) begin
                            r_c[r_k] <= -$signed({3'b000, div_q});
                        end else begin
                            r_c[r_k] <= $signed({3'b000, div_q});
                        end
                        r_k   <= r_k + 4'd1;
                        r_grp <= G_BX;
                        r_j   <= '0;
                        r_ph  <= PH_MUL;
                    end
                end
                S_MAC: begin
                    case (r_ph)
                        PH_MUL: begin
                            r_prod <= mul_p;
                            r_ph   <= PH_ACC;
                        end
                        PH_ACC: begin
                            r_acc <= ((r_j == 2'd0) ? '0 : r_acc) + ACC_W'(r_prod);
                            if (last_term(r_grp, r_j)) begin
                                r_ph <= PH_WB;
                            end else begin
                                r_j  <= r_j + 2'd1;
                                r_ph <= PH_MUL;
                            end
                        end
                        default: begin
                            case (r_grp)
                                G_BX: r_bx <= (rnd > ERR_LIM) ? 35'(ERR_LIM) :
                                    (rnd < -ERR_LIM) ? 35'(-ERR_LIM) : rnd[34:0];
                                G_BY: r_by <= (rnd > ERR_LIM) ? 35'(ERR_LIM) :
                                    (rnd < -ERR_LIM) ? 35'(-ERR_LIM) : rnd[34:0];
                                G_BZ: r_bz <= rnd[34:0];
                                G_VX: r_vx <= (rnd > ERR_LIM) ? 35'(ERR_LIM) :
                                    (rnd < -ERR_LIM) ? 35'(-ERR_LIM) : rnd[34:0];
                                G_VY: r_vy <= (rnd > ERR_LIM) ? 35'(ERR_LIM) :
                                    (rnd < -ERR_LIM) ? 35'(-ERR_LIM) : rnd[34:0];
                                G_THR: r_w_thrust <= (rnd > THR_MAX) ? 32'(THR_MAX) :
                                    (rnd < THR_MIN) ? 32'(THR_MIN) : rnd[31:0];
                                G_ROLL: r_w_roll <= (rnd_neg > ANGLE_LIM) ? 14'(ANGLE_LIM) :
                                    (rnd_neg < -ANGLE_LIM) ? 14'(-ANGLE_LIM) : rnd_neg[13:0];
                                default: r_w_pitch <= (rnd > ANGLE_LIM) ? 14'(ANGLE_LIM) :
                                    (rnd < -ANGLE_LIM) ? 14'(-ANGLE_LIM) : rnd[13:0];
                            endcase
                            r_grp <= r_grp + 3'd1;
                            r_j   <= '0;
                            r_ph  <= PH_MUL;
                        end
                    endcase
                end
                S_OUT: begin
                    if (!r_o_valid || i_ready) begin
                        r_o_thrust <= r_w_thrust;
                        r_o_roll   <= r_w_roll;
                        r_o_pitch  <= r_w_pitch;
                    end
                end
                default: ;
            endcase
        end
    end

endmodule

/* hdl/cpas_checker.sv */
// cpas_checker: port-level assertions for cascaded_position_attitude_setpoint
// bound to the top level below; no package dependency

module cpas_checker #(
    parameter int FRAC_BITS = 16
) (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_valid,
    input logic               o_ready,
    input logic               o_valid,
    input logic               i_ready,
    input logic signed [31:0] o_thrust_cmd,
    input logic signed [13:0] o_roll_cmd,
    input logic signed [13:0] o_pitch_cmd
);

    localparam longint ANGLE_LIM = ((longint'(75) <<< FRAC_BITS) + 500) / 1000;
    localparam logic FITS = (ANGLE_LIM < 8192);

    // stalled result transaction holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_thrust_cmd)
            && $stable(o_roll_cmd) && $stable(o_pitch_cmd))
        else $error("result changed while stalled");

    // one item in work at a time
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> !o_ready)
        else $error("input taken while busy");

    a_angle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && FITS |-> $signed(o_roll_cmd) <= ANGLE_LIM
            && $signed(o_roll_cmd) >= -ANGLE_LIM
            && $signed(o_pitch_cmd) <= ANGLE_LIM
            && $signed(o_pitch_cmd) >= -ANGLE_LIM)
        else $error("angle command beyond limit");

    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && o_ready)
        else $error("not empty after reset");

endmodule

bind cascaded_position_attitude_setpoint cpas_checker #(.FRAC_BITS(FRAC_BITS)) u_cpas_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_valid      (i_valid),
    .o_ready      (o_ready),
    .o_valid      (o_valid),
    .i_ready      (i_ready),
    .o_thrust_cmd (o_thrust_cmd),
    .o_roll_cmd   (o_roll_cmd),
    .o_pitch_cmd  (o_pitch_cmd)
);
